@@ hdl/twh_pkg.sv @@
package twh_pkg;

    // Fixed field widths
    localparam int WL_W       = 14;
    localparam int TNS_W      = 32;
    localparam int SCALE_W    = 16;
    localparam int WEIGHT_W   = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_TIMING_ENABLE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NS_PER_UNIT   = 4'd1;

    localparam logic [SCALE_W-1:0]  SCALE_RESET = 16'd66;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE  = 16'd256;

    // exp(-1/20) and exp(+1/20) in Q32, unity and cap in Q24, weight cap in Q8.8
    localparam logic [63:0] EXP_DOWN_Q32 = 64'd4085499269;
    localparam logic [63:0] EXP_UP_Q32   = 64'd4515174978;
    localparam logic [63:0] E_ONE_Q24    = 64'd1 << 24;
    localparam logic [63:0] E_CAP_Q24    = 64'd4 << 24;
    localparam logic [63:0] W_CAP        = 64'd1280;

    typedef enum logic [17:0] {
        ST_IDLE   = 18'b000000000000000001,
        ST_DECODE = 18'b000000000000000010,
        ST_SLK    = 18'b000000000000000100,
        ST_TNS    = 18'b000000000000001000,
        ST_MINC   = 18'b000000000000010000,
        ST_XLO    = 18'b000000000000100000,
        ST_XHI    = 18'b000000000001000000,
        ST_YLO    = 18'b000000000010000000,
        ST_YHI    = 18'b000000000100000000,
        ST_DX     = 18'b000000001000000000,
        ST_DY     = 18'b000000010000000000,
        ST_HSUM   = 18'b000000100000000000,
        ST_MUL1   = 18'b000001000000000000,
        ST_IDX    = 18'b000010000000000000,
        ST_ROM    = 18'b000100000000000000,
        ST_MUL2   = 18'b001000000000000000,
        ST_EMIT   = 18'b010000000000000000,
        ST_SPARE  = 18'b100000000000000000
    } state_t;

    // Q24 exponent to Q8.8 weight, rounded, capped at 5.0
    function automatic logic [WEIGHT_W-1:0] weight_of(input logic [63:0] e);
        logic [63:0] w;
        w = 64'd256 + ((e + 64'd32768) >> 16);
        return (w > W_CAP) ? W_CAP[WEIGHT_W-1:0] : w[WEIGHT_W-1:0];
    endfunction

    // Q24 times Q32, rounded half up, capped at 4.0
    function automatic logic [63:0] mul_q32(input logic [63:0] e, input logic [63:0] k);
        logic [63:0] p;
        p = (e * k + (64'd1 << 31)) >> 32;
        return (p > E_CAP_Q24) ? E_CAP_Q24 : p;
    endfunction

endpackage

@@ hdl/timing_weighted_hpwl.sv @@
// Timing-weighted half-perimeter wirelength of one net. A net arrives on the
// s_ channel as a driver transaction (s_tuser = 0) followed by load
// transactions (s_tuser = 1); s_tlast closes the net. The block tracks the
// bounding box of placed, non-global-buffer pins and, when timing is enabled
// and the driver is a timed port in cost mode, the saturated sum of negative
// slacks and the worst slack. A net whose driver is unplaced or sits on a
// global buffer produces no result. On the closing transaction one result is
// sent on the m_ channel: wirelength = floor(hpwl * w / 256), where w is a
// Q8.8 weight min(5, 1 + exp(-ns/5)) looked up by worst slack in ns, or 1.0
// when timing is off. All arithmetic goes through one shared add/subtract
// unit and one shared multiplier under a one-hot sequencer, and s_tready is
// high only while the sequencer is idle. After decoding, a placed load of a
// counted net runs the slack, tns and worst-slack updates when timing is
// active and the four box compares unless it sits on a global buffer, then
// returns to idle. The closing transaction adds the box extents, a weight of
// one or the lookup (slack scaling multiply, index clamp, registered table
// read), the final multiply and the output load, which waits until the
// previous result has left the output register. The weight table is a
// constant ROM built at elaboration; there is no clearing pass.
// Configuration writes are always taken (cfg_ready is tied high) and are
// meant to happen only while no net is in flight.
module timing_weighted_hpwl #(
    parameter int COORD_BITS     = 10,
    parameter int DELAY_BITS     = 24,
    parameter int WEIGHT_ENTRIES = 256,
    localparam int S_W           = 2 * COORD_BITS + 4 + 2 * DELAY_BITS,
    localparam int S_TDATA_W     = ((S_W + 7) / 8) * 8,
    localparam int M_W           = twh_pkg::WL_W + twh_pkg::TNS_W + DELAY_BITS,
    localparam int M_TDATA_W     = ((M_W + 7) / 8) * 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    // Configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [twh_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [twh_pkg::CFG_DATA_W-1:0]      cfg_data,

    // Pin stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // pos_x, pos_y, is_placed, global_buffer, timed_port, cost_mode,
    // slack_budget, predicted_delay, zero pad
    input  logic [S_TDATA_W-1:0]                s_tdata,
    // item_kind
    input  logic                                s_tuser,
    input  logic                                s_tlast,

    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // wirelength, tns_delta, worst slack, zero pad
    output logic [M_TDATA_W-1:0]                m_tdata
);
    import twh_pkg::*;

    localparam int C        = COORD_BITS;
    localparam int D        = DELAY_BITS;
    localparam int IDX_W    = $clog2(WEIGHT_ENTRIES);
    localparam int HALF     = WEIGHT_ENTRIES / 2;
    // wide enough for delay differences, the tns sum and the scaled slack
    localparam int ALU_W    = (D + 5 > 34) ? D + 5 : 34;
    localparam int MUL_A_W  = (D > C + 2) ? D : C + 2;
    localparam int MUL_B_W  = WEIGHT_W + 1;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int NS_SHIFT = 14;              // Q16 ns to quarter-ns steps

    // s_tdata field offsets
    localparam int X_LO  = 0;
    localparam int Y_LO  = C;
    localparam int PL_B  = 2 * C;
    localparam int GB_B  = 2 * C + 1;
    localparam int TP_B  = 2 * C + 2;
    localparam int CM_B  = 2 * C + 3;
    localparam int SB_LO = 2 * C + 4;
    localparam int PD_LO = 2 * C + 4 + D;

    localparam logic signed [D-1:0]     DMAX    = {1'b0, {(D-1){1'b1}}};
    localparam logic signed [D-1:0]     DMIN    = {1'b1, {(D-1){1'b0}}};
    localparam logic signed [TNS_W-1:0] TNS_MIN = {1'b1, {(TNS_W-1){1'b0}}};

    // ---------------------------------------------------------------------
    // Weight ROM: entry i stands for ns = (i - HALF) / 4
    // ---------------------------------------------------------------------
    typedef logic [WEIGHT_W-1:0] wtab_t [WEIGHT_ENTRIES];

    function automatic wtab_t build_weights();
        wtab_t       tab;
        logic [63:0] e;
        int          i;
        e = E_ONE_Q24;
        for (i = HALF; i < WEIGHT_ENTRIES; i++) begin
            tab[i] = weight_of(e);
            e      = mul_q32(e, EXP_DOWN_Q32);
        end
        e = E_ONE_Q24;
        for (i = HALF - 1; i >= 0; i--) begin
            e      = mul_q32(e, EXP_UP_Q32);
            tab[i] = weight_of(e);
        end
        return tab;
    endfunction

    localparam wtab_t WEIGHT_ROM = build_weights();

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    state_t                     state_reg, state_next;

    logic                       timing_enable_reg;
    logic [SCALE_W-1:0]         ns_scale_reg;

    // captured transaction
    logic                       kind_reg;
    logic [C-1:0]               x_reg, y_reg;
    logic                       placed_reg, gbuf_reg, timed_reg, cost_reg, last_reg;
    logic signed [D-1:0]        budget_reg, delay_reg;

    // net state
    logic [C-1:0]               box_xmin_reg, box_xmin_next;
    logic [C-1:0]               box_xmax_reg, box_xmax_next;
    logic [C-1:0]               box_ymin_reg, box_ymin_next;
    logic [C-1:0]               box_ymax_reg, box_ymax_next;
    logic signed [TNS_W-1:0]    neg_sum_reg, neg_sum_next;
    logic signed [D-1:0]        min_slack_reg, min_slack_next;
    logic                       timing_active_reg, timing_active_next;
    logic                       net_counted_reg, net_counted_next;

    // working registers
    logic signed [D-1:0]        slack_reg, slack_next;
    logic [C:0]                 hpwl_reg, hpwl_next;
    logic [C-1:0]               dy_reg, dy_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [WEIGHT_W-1:0]        weight_reg, weight_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;

    logic                       m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]       m_tdata_reg, m_tdata_next;

    // shared units
    logic signed [ALU_W-1:0]    alu_a, alu_b, alu_res;
    logic                       alu_sub;
    logic                       alu_neg;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   mul_res;

    logic                       s_accept;
    logic                       slack_ovf;
    logic                       tns_ovf;
    state_t                     finish_state;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // one add/subtract unit, one multiplier
    assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    assign alu_neg = alu_res[ALU_W-1];
    assign mul_res = mul_a * mul_b;

    assign slack_ovf = (alu_res[ALU_W-1:D-1] != {(ALU_W-D+1){alu_res[ALU_W-1]}});
    // only used when adding a negative slack to the non-positive sum
    assign tns_ovf   = (alu_res[ALU_W-1:TNS_W-1] != {(ALU_W-TNS_W+1){1'b1}});

    // where a load goes once its updates are done
    assign finish_state = last_reg ? ST_DX : ST_IDLE;

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_comb begin
        state_next         = state_reg;
        box_xmin_next      = box_xmin_reg;
        box_xmax_next      = box_xmax_reg;
        box_ymin_next      = box_ymin_reg;
        box_ymax_next      = box_ymax_reg;
        neg_sum_next       = neg_sum_reg;
        min_slack_next     = min_slack_reg;
        timing_active_next = timing_active_reg;
        net_counted_next   = net_counted_reg;
        slack_next         = slack_reg;
        hpwl_next          = hpwl_reg;
        dy_next            = dy_reg;
        idx_next           = idx_reg;
        weight_next        = weight_reg;
        prod_next          = prod_reg;
        m_tdata_next       = m_tdata_reg;
        m_tvalid_next      = m_tvalid_reg && !m_tready;

        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
        mul_a   = '0;
        mul_b   = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE: begin
                if (!kind_reg) begin
                    // driver opens a net
                    neg_sum_next       = '0;
                    min_slack_next     = DMAX;
                    box_xmin_next      = x_reg;
                    box_xmax_next      = x_reg;
                    box_ymin_next      = y_reg;
                    box_ymax_next      = y_reg;
                    net_counted_next   = placed_reg && !gbuf_reg;
                    timing_active_next = timing_enable_reg && cost_reg && timed_reg;
                    state_next = (last_reg && placed_reg && !gbuf_reg) ? ST_DX : ST_IDLE;
                end else if (net_counted_reg && placed_reg) begin
                    if (timing_active_reg) begin
                        state_next = ST_SLK;
                    end else begin
                        state_next = gbuf_reg ? finish_state : ST_XLO;
                    end
                end else begin
                    state_next = (last_reg && net_counted_reg) ? ST_DX : ST_IDLE;
                end
            end

            ST_SLK: begin
                alu_a = ALU_W'(budget_reg);
                alu_b = ALU_W'(delay_reg);
                if (slack_ovf) begin
                    slack_next = alu_neg ? DMIN : DMAX;
                end else begin
                    slack_next = alu_res[D-1:0];
                end
                state_next = ST_TNS;
            end

            ST_TNS: begin
                alu_a   = ALU_W'(neg_sum_reg);
                alu_b   = ALU_W'(slack_reg);
                alu_sub = 1'b0;
                if (slack_reg[D-1]) begin
                    neg_sum_next = tns_ovf ? TNS_MIN : alu_res[TNS_W-1:0];
                end
                state_next = ST_MINC;
            end

            ST_MINC: begin
                alu_a = ALU_W'(slack_reg);
                alu_b = ALU_W'(min_slack_reg);
                if (alu_neg) begin
                    min_slack_next = slack_reg;
                end
                // global-buffer loads count for slack only
                state_next = gbuf_reg ? finish_state : ST_XLO;
            end

            ST_XLO: begin
                alu_a = ALU_W'(x_reg);
                alu_b = ALU_W'(box_xmin_reg);
                if (alu_neg) begin
                    box_xmin_next = x_reg;
                end
                state_next = ST_XHI;
            end

            ST_XHI: begin
                alu_a = ALU_W'(box_xmax_reg);
                alu_b = ALU_W'(x_reg);
                if (alu_neg) begin
                    box_xmax_next = x_reg;
                end
                state_next = ST_YLO;
            end

            ST_YLO: begin
                alu_a = ALU_W'(y_reg);
                alu_b = ALU_W'(box_ymin_reg);
                if (alu_neg) begin
                    box_ymin_next = y_reg;
                end
                state_next = ST_YHI;
            end

            ST_YHI: begin
                alu_a = ALU_W'(box_ymax_reg);
                alu_b = ALU_W'(y_reg);
                if (alu_neg) begin
                    box_ymax_next = y_reg;
                end
                state_next = finish_state;
            end

            ST_DX: begin
                alu_a            = ALU_W'(box_xmax_reg);
                alu_b            = ALU_W'(box_xmin_reg);
                hpwl_next        = alu_res[C:0];
                net_counted_next = 1'b0;
                state_next       = ST_DY;
            end

            ST_DY: begin
                alu_a      = ALU_W'(box_ymax_reg);
                alu_b      = ALU_W'(box_ymin_reg);
                dy_next    = alu_res[C-1:0];
                state_next = ST_HSUM;
            end

            ST_HSUM: begin
                alu_a     = ALU_W'(hpwl_reg);
                alu_b     = ALU_W'(dy_reg);
                alu_sub   = 1'b0;
                hpwl_next = alu_res[C:0];
                if (timing_active_reg) begin
                    state_next = ST_MUL1;
                end else begin
                    weight_next = WEIGHT_ONE;
                    state_next  = ST_MUL2;
                end
            end

            ST_MUL1: begin
                // worst slack in ns, Q16
                mul_a      = MUL_A_W'(min_slack_reg);
                mul_b      = MUL_B_W'(ns_scale_reg);
                prod_next  = mul_res;
                state_next = ST_IDX;
            end

            ST_IDX: begin
                // floor to quarter-ns, centre on the table, clamp
                alu_a   = ALU_W'(prod_reg >>> NS_SHIFT);
                alu_b   = ALU_W'(HALF);
                alu_sub = 1'b0;
                if (alu_neg) begin
                    idx_next = '0;
                end else if (alu_res > $signed(ALU_W'(WEIGHT_ENTRIES - 1))) begin
                    idx_next = IDX_W'(WEIGHT_ENTRIES - 1);
                end else begin
                    idx_next = alu_res[IDX_W-1:0];
                end
                state_next = ST_ROM;
            end

            ST_ROM: begin
                weight_next = WEIGHT_ROM[idx_reg];
                state_next  = ST_MUL2;
            end

            ST_MUL2: begin
                mul_a      = MUL_A_W'(hpwl_reg);
                mul_b      = MUL_B_W'(weight_reg);
                prod_next  = mul_res;
                state_next = ST_EMIT;
            end

            ST_EMIT: begin
                // wait for the output register to free up
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({min_slack_reg, neg_sum_reg,
                                                prod_reg[8 +: WL_W]});
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Clocked
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            timing_enable_reg <= 1'b0;
            ns_scale_reg      <= SCALE_RESET;
            timing_active_reg <= 1'b0;
            net_counted_reg   <= 1'b0;
            box_xmin_reg      <= '0;
            box_xmax_reg      <= '0;
            box_ymin_reg      <= '0;
            box_ymax_reg      <= '0;
            neg_sum_reg       <= '0;
            min_slack_reg     <= DMAX;
            m_tvalid_reg      <= 1'b0;
        end else begin
            state_reg         <= state_next;
            timing_active_reg <= timing_active_next;
            net_counted_reg   <= net_counted_next;
            box_xmin_reg      <= box_xmin_next;
            box_xmax_reg      <= box_xmax_next;
            box_ymin_reg      <= box_ymin_next;
            box_ymax_reg      <= box_ymax_next;
            neg_sum_reg       <= neg_sum_next;
            min_slack_reg     <= min_slack_next;
            m_tvalid_reg      <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_TIMING_ENABLE: timing_enable_reg <= cfg_data[0];
                    CFG_NS_PER_UNIT:   ns_scale_reg      <= cfg_data[SCALE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge aclk) begin
        slack_reg   <= slack_next;
        hpwl_reg    <= hpwl_next;
        dy_reg      <= dy_next;
        idx_reg     <= idx_next;
        weight_reg  <= weight_next;
        prod_reg    <= prod_next;
        m_tdata_reg <= m_tdata_next;
        if (s_accept) begin
            kind_reg   <= s_tuser;
            last_reg   <= s_tlast;
            x_reg      <= s_tdata[X_LO +: C];
            y_reg      <= s_tdata[Y_LO +: C];
            placed_reg <= s_tdata[PL_B];
            gbuf_reg   <= s_tdata[GB_B];
            timed_reg  <= s_tdata[TP_B];
            cost_reg   <= s_tdata[CM_B];
            budget_reg <= s_tdata[SB_LO +: D];
            delay_reg  <= s_tdata[PD_LO +: D];
        end
    end

endmodule
